### rtl/swsd_pkg.sv
// shared constants, register indexes, state and struct types of the
// sliding-window silence detector; no dependencies
package swsd_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int INDEX_W        = 32;
  localparam int SPREAD_W       = 16;
  localparam int WIN_LEN_W      = 11;
  localparam int THRESH_W       = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 16;
  localparam int WINDOW_MAX_DEF = 1024;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    Q_IDLE,
    Q_FRONT,
    Q_BACK,
    Q_SCAN
  } qstate_e;

  typedef enum logic {
    T_IDLE,
    T_RUN
  } tstate_e;

  typedef struct packed {
    logic                       start;
    logic                       restart;
    logic signed [SAMPLE_W-1:0] value;
  } qcmd_t;

  typedef struct packed {
    logic                       busy;
    logic signed [SAMPLE_W-1:0] best;
  } qstat_t;

endpackage

### rtl/swsd_if.sv
// valid/ready channel interfaces: sample input, result output, config write
// depends on swsd_pkg
interface swsd_in_if import swsd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       restart;

  modport source (output valid, sample, restart, input ready);
  modport sink (input valid, sample, restart, output ready);
endinterface

interface swsd_out_if import swsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [INDEX_W-1:0]  start_index;
  logic [SPREAD_W-1:0] spread;

  modport source (output valid, start_index, spread, input ready);
  modport sink (input valid, start_index, spread, output ready);
endinterface

interface swsd_cfg_if import swsd_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/sliding_window_silence_detector_top.sv
// sliding-window silence detector top: config, sample count, max and min queues, result reg
// depends on swsd_pkg, swsd_if, swsd_queue
// flow: per sample beat both queues drop a stale front, pop back candidates, push the
// sample and search the front; a silent result is registered once both idle, output free
// a new beat is taken only after that, so a held result stalls the input
// reset: queues empty, count and write position zero, window length 1, threshold 0
module sliding_window_silence_detector_top import swsd_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input logic         clk_i,
  input logic         rst_ni,
  swsd_cfg_if.sink    cfg_i,
  swsd_in_if.sink     in_i,
  swsd_out_if.source  out_o
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int LW = $clog2(WINDOW_MAX + 1);

  tstate_e              state_q, state_d;
  logic [WIN_LEN_W-1:0] win_len_q;
  logic [THRESH_W-1:0]  thr_q;
  logic [INDEX_W-1:0]   count_q, count_d;
  logic [AW-1:0]        cur_q;
  logic                 out_valid_q, out_valid_d;
  logic [INDEX_W-1:0]   out_start_q;
  logic [SPREAD_W-1:0]  out_spread_q;

  logic                 in_beat;
  logic                 busy;
  logic                 out_free;
  logic                 emit;
  logic                 silent;
  logic [INDEX_W-1:0]   wl_ext;
  logic [INDEX_W-1:0]   w_ext;
  logic [LW-1:0]        w_eff;
  logic [INDEX_W-1:0]   count_base;
  logic [SAMPLE_W:0]    diff;
  logic [SPREAD_W-1:0]  spread;
  logic [INDEX_W-1:0]   start_idx;
  qcmd_t                qcmd;
  qstat_t               max_st;
  qstat_t               min_st;

  // effective window length: zero acts as one, capped at the queue depth
  always_comb begin
    wl_ext = INDEX_W'(win_len_q);
    if (wl_ext == '0) begin
      w_ext = INDEX_W'(1);
    end else if (wl_ext > INDEX_W'(WINDOW_MAX)) begin
      w_ext = INDEX_W'(WINDOW_MAX);
    end else begin
      w_ext = wl_ext;
    end
    w_eff = w_ext[LW-1:0];
  end

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_len_q <= WIN_LEN_W'(1);
      thr_q     <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        CFG_WINDOW_LEN: win_len_q <= cfg_i.data[WIN_LEN_W-1:0];
        CFG_THRESHOLD:  thr_q     <= cfg_i.data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_beat       = in_i.valid && in_i.ready;
  assign qcmd.start    = in_beat;
  assign qcmd.restart  = in_i.restart;
  assign qcmd.value    = in_i.sample;

  swsd_queue #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_max_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (qcmd),
    .cur_i      (cur_q),
    .win_i      (w_eff),
    .keep_max_i (1'b1),
    .stat_o     (max_st)
  );

  swsd_queue #(
    .WINDOW_MAX (WINDOW_MAX)
  ) u_min_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (qcmd),
    .cur_i      (cur_q),
    .win_i      (w_eff),
    .keep_max_i (1'b0),
    .stat_o     (min_st)
  );

  assign busy     = max_st.busy || min_st.busy;
  assign out_free = !out_valid_q || out_o.ready;

  // saturating sample count, cleared by restart
  always_comb begin
    count_base = in_i.restart ? '0 : count_q;
    count_d    = count_q;
    if (in_beat) begin
      count_d = (count_base == '1) ? count_base : count_base + INDEX_W'(1);
    end
  end

  always_comb begin
    diff      = {max_st.best[SAMPLE_W-1], max_st.best} - {min_st.best[SAMPLE_W-1], min_st.best};
    spread    = diff[SPREAD_W-1:0];
    silent    = (count_q >= w_ext) && (spread <= thr_q);
    start_idx = (count_q == '1) ? '1 : count_q - w_ext + INDEX_W'(1);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (in_beat) begin
          state_d = T_RUN;
        end
      end
      T_RUN: begin
        if (!busy && out_free) begin
          state_d = T_IDLE;
        end
      end
      default: state_d = T_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_i.ready  = (state_q == T_IDLE);
    emit        = (state_q == T_RUN) && !busy && out_free && silent;
    out_valid_d = out_valid_q;
    if (emit) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      count_q     <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (in_beat) begin
        cur_q <= (cur_q == AW'(WINDOW_MAX - 1)) ? '0 : cur_q + AW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_start_q  <= start_idx;
      out_spread_q <= spread;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.start_index = out_start_q;
  assign out_o.spread      = out_spread_q;

  a_idle_queues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !busy)
    else $error("sample taken while a queue update is in flight");

  a_spread_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_o.valid && (out_o.spread <= $past(thr_q)))
    else $error("result spread above threshold");

  a_start_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit |=> out_o.start_index != '0)
    else $error("result start index is zero");

endmodule

### rtl/swsd_ram.sv
// generic single-write, single-read ram with registered read data
// depends on swsd_pkg for default sizes
module swsd_ram import swsd_pkg::*; #(
  parameter int WIDTH = SAMPLE_W,
  parameter int DEPTH = WINDOW_MAX_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/swsd_queue.sv
// monotonic candidate queue kept in a ram: stale drop, back pops, push and
// in-window front search for one sample; depends on swsd_pkg and swsd_ram
module swsd_queue import swsd_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  qcmd_t                             cmd_i,
  input  logic [$clog2(WINDOW_MAX)-1:0]     cur_i,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]   win_i,
  input  logic                              keep_max_i,
  output qstat_t                            stat_o
);

  localparam int AW = $clog2(WINDOW_MAX);
  localparam int LW = $clog2(WINDOW_MAX + 1);
  localparam int SW = LW + 1;
  localparam int EW = AW + SAMPLE_W;

  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] base, logic [LW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(WINDOW_MAX)) begin
      sum = sum - SW'(WINDOW_MAX);
    end
    return sum[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] age_of(logic [AW-1:0] cur, logic [AW-1:0] pos);
    logic [SW-1:0] diff;
    diff = SW'(cur) + SW'(WINDOW_MAX) - SW'(pos);
    if (diff >= SW'(WINDOW_MAX)) begin
      diff = diff - SW'(WINDOW_MAX);
    end
    return diff[AW-1:0];
  endfunction

  qstate_e                    state_q, state_d;
  logic [AW-1:0]              head_q, head_d;
  logic [LW-1:0]              len_q, len_d;
  logic [LW-1:0]              skip_q, skip_d;
  logic [LW-1:0]              win_q, win_d;
  logic [AW-1:0]              cur_q, cur_d;
  logic signed [SAMPLE_W-1:0] val_q, val_d;
  logic signed [SAMPLE_W-1:0] best_q, best_d;

  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [EW-1:0]              ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [EW-1:0]              ram_rdata;
  logic [AW-1:0]              rd_pos;
  logic signed [SAMPLE_W-1:0] rd_val;

  logic [AW-1:0]              h;
  logic [LW-1:0]              l;
  logic [LW-1:0]              s;
  logic [LW-1:0]              s_inc;
  logic [AW-1:0]              p_new;
  logic signed [SAMPLE_W-1:0] v_new;
  logic                       push;
  logic                       push_fin;
  logic                       stale;
  logic                       pop;
  logic                       hit;
  logic                       last;

  swsd_ram #(
    .WIDTH (EW),
    .DEPTH (WINDOW_MAX)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_pos = ram_rdata[EW-1:SAMPLE_W];
  assign rd_val = signed'(ram_rdata[SAMPLE_W-1:0]);

  // queue bookkeeping for the current step
  always_comb begin
    h     = head_q;
    l     = len_q;
    s     = skip_q;
    s_inc = skip_q + LW'(1);
    p_new = cur_q;
    v_new = val_q;
    push  = 1'b0;
    stale = 1'b0;
    pop   = 1'b0;
    hit   = 1'b0;
    last  = 1'b0;
    unique case (state_q)
      Q_IDLE: begin
        if (cmd_i.start) begin
          h     = cmd_i.restart ? '0 : head_q;
          l     = cmd_i.restart ? '0 : len_q;
          s     = (cmd_i.restart || (win_i != win_q)) ? '0 : skip_q;
          p_new = cur_i;
          v_new = cmd_i.value;
          push  = (l == '0);
        end
      end
      Q_FRONT: begin
        stale = (rd_pos == cur_q);
        if (stale) begin
          h = wrap_add(head_q, LW'(1));
          l = len_q - LW'(1);
          if (skip_q != '0) begin
            s = skip_q - LW'(1);
          end
        end
        push = (l == '0);
      end
      Q_BACK: begin
        pop = keep_max_i ? (rd_val <= val_q) : (rd_val >= val_q);
        if (pop) begin
          l = len_q - LW'(1);
        end
        if (s > l) begin
          s = l;
        end
        push = !pop || (l == '0);
      end
      Q_SCAN: begin
        hit  = (LW'(age_of(cur_q, rd_pos)) < win_q);
        last = (s_inc == len_q - LW'(1));
      end
      default: ;
    endcase
    push_fin = (s == l);
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      Q_IDLE: begin
        if (cmd_i.start) begin
          state_d = push ? (push_fin ? Q_IDLE : Q_SCAN) : Q_FRONT;
        end
      end
      Q_FRONT: begin
        state_d = push ? (push_fin ? Q_IDLE : Q_SCAN) : Q_BACK;
      end
      Q_BACK: begin
        state_d = push ? (push_fin ? Q_IDLE : Q_SCAN) : Q_BACK;
      end
      Q_SCAN: begin
        if (hit || last) begin
          state_d = Q_IDLE;
        end
      end
      default: state_d = Q_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    head_d    = head_q;
    len_d     = len_q;
    skip_d    = skip_q;
    win_d     = win_q;
    cur_d     = cur_q;
    val_d     = val_q;
    best_d    = best_q;
    ram_we    = 1'b0;
    ram_waddr = wrap_add(h, l);
    ram_wdata = {p_new, v_new};
    ram_raddr = h;
    unique case (state_q)
      Q_IDLE: begin
        if (cmd_i.start) begin
          cur_d  = cur_i;
          val_d  = cmd_i.value;
          win_d  = win_i;
          head_d = h;
          len_d  = l;
          skip_d = s;
        end
      end
      Q_FRONT: begin
        head_d    = h;
        len_d     = l;
        skip_d    = s;
        ram_raddr = wrap_add(h, l - LW'(1));
      end
      Q_BACK: begin
        len_d     = l;
        skip_d    = s;
        ram_raddr = wrap_add(h, l - LW'(1));
      end
      Q_SCAN: begin
        if (hit) begin
          best_d = rd_val;
        end else begin
          skip_d = s_inc;
          if (last) begin
            best_d = val_q;
          end else begin
            ram_raddr = wrap_add(head_q, s_inc);
          end
        end
      end
      default: ;
    endcase
    if (push) begin
      ram_we = 1'b1;
      head_d = h;
      len_d  = l + LW'(1);
      skip_d = s;
      if (push_fin) begin
        best_d = v_new;
      end else begin
        ram_raddr = wrap_add(h, s);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Q_IDLE;
      head_q  <= '0;
      len_q   <= '0;
      skip_q  <= '0;
      win_q   <= LW'(1);
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      len_q   <= len_d;
      skip_q  <= skip_d;
      win_q   <= win_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q  <= cur_d;
    val_q  <= val_d;
    best_q <= best_d;
  end

  assign stat_o.busy = (state_q != Q_IDLE);
  assign stat_o.best = best_q;

endmodule

### tb/swsd_silence_checker.sv
`timescale 1ns / 100ps
// silence detector checker: watches the config, sample and result channels,
// predicts each silent window and compares result beats in order
// depends on swsd_pkg and swsd_if
module swsd_silence_checker import swsd_pkg::*; #(
  parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  swsd_cfg_if         cfg_i,
  swsd_in_if          smp_i,
  swsd_out_if         res_i,
  output int unsigned errors_o,
  output int unsigned pending_o
);

  typedef struct packed {
    logic [INDEX_W-1:0]  start_index;
    logic [SPREAD_W-1:0] spread;
  } silent_window_t;

  silent_window_t             silent_windows_q[$];
  logic signed [SAMPLE_W-1:0] history [WINDOW_MAX];
  logic [WIN_LEN_W-1:0]       win_len;
  logic [THRESH_W-1:0]        thr;
  logic [INDEX_W-1:0]         taken;
  logic [31:0]                wr_pos;
  int unsigned                mismatches;

  task automatic predict_silent_window(input logic signed [SAMPLE_W-1:0] smp,
                                       input logic rs);
    int unsigned    w;
    int unsigned    k;
    int unsigned    spr;
    int             hi;
    int             lo;
    int             v;
    silent_window_t rec;
    w = (win_len == '0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : win_len);
    if (rs) begin
      taken = '0;
    end
    history[wr_pos % WINDOW_MAX] = smp;
    if (taken != '1) begin
      taken = taken + 1'b1;
    end
    if (taken >= w) begin
      hi = smp;
      lo = smp;
      for (k = 1; k < w; k++) begin
        v = history[(wr_pos - k) % WINDOW_MAX];
        if (v > hi) hi = v;
        if (v < lo) lo = v;
      end
      spr = hi - lo;
      if (spr <= thr) begin
        rec.start_index = (taken == '1) ? '1 : taken - w + 1;
        rec.spread      = spr[SPREAD_W-1:0];
        silent_windows_q.push_back(rec);
      end
    end
    wr_pos = wr_pos + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    silent_window_t want;
    if (!rst_ni) begin
      win_len    = WIN_LEN_W'(1);
      thr        = '0;
      taken      = '0;
      wr_pos     = '0;
      mismatches = 0;
      silent_windows_q.delete();
    end else begin
      if (res_i.valid && res_i.ready) begin
        if (silent_windows_q.size() == 0) begin
          $error("unexpected beat: start_index %0d spread %0d",
                 res_i.start_index, res_i.spread);
          mismatches++;
        end else begin
          want = silent_windows_q.pop_front();
          if (res_i.start_index !== want.start_index) begin
            $error("start_index: expected %0d, actual %0d",
                   want.start_index, res_i.start_index);
            mismatches++;
          end
          if (res_i.spread !== want.spread) begin
            $error("spread: expected %0d, actual %0d", want.spread, res_i.spread);
            mismatches++;
          end
        end
      end
      if (smp_i.valid && smp_i.ready) begin
        predict_silent_window(smp_i.sample, smp_i.restart);
      end
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_WINDOW_LEN: win_len = cfg_i.data[WIN_LEN_W-1:0];
          CFG_THRESHOLD:  thr = cfg_i.data[THRESH_W-1:0];
          default: ;
        endcase
      end
    end
    errors_o  <= mismatches;
    pending_o <= silent_windows_q.size();
  end

endmodule

### tb/sliding_window_silence_detector_top_tb.sv
`timescale 1ns / 100ps
// testbench top of the silence detector: clock, reset, sample, config and
// result drain stimulus, watchdog and verdict
// depends on swsd_pkg, swsd_if, sliding_window_silence_detector_top, swsd_silence_checker
module sliding_window_silence_detector_top_tb;
  import swsd_pkg::*;

  localparam int WINDOW_MAX     = WINDOW_MAX_DEF;
  localparam int SETTLE_CYCLES  = 2 * WINDOW_MAX + 32;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int PHASES         = 9;
  localparam int LARGE_PHASE    = 4;
  localparam int PHASE_BEATS    = 40;
  localparam int LARGE_RUN      = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = CFG_IDX_W'(2);

  logic        clk_i;
  logic        rst_ni;
  bit          idle_en;
  int unsigned errors;
  int unsigned pending;
  int unsigned quiet_cycles;
  int unsigned beats_sent;

  swsd_in_if  samples_if();
  swsd_out_if windows_if();
  swsd_cfg_if cfg_if();

  sliding_window_silence_detector_top #(
    .WINDOW_MAX(WINDOW_MAX)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (samples_if),
    .out_o (windows_if)
  );

  swsd_silence_checker #(
    .WINDOW_MAX(WINDOW_MAX)
  ) i_checker (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_if),
    .smp_i    (samples_if),
    .res_i    (windows_if),
    .errors_o (errors),
    .pending_o(pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // result side stalls in bursts
  initial begin : drain
    windows_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (idle_en && $urandom_range(0, 3) == 0) begin
        windows_if.ready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end
      windows_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((samples_if.valid && samples_if.ready) || (windows_if.valid && windows_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic push_sample(input logic [SAMPLE_W-1:0] value, input logic rs);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      samples_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    samples_if.valid   <= 1'b1;
    samples_if.sample  <= value;
    samples_if.restart <= rs;
    @(posedge clk_i);
    while (!samples_if.ready) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      cfg_if.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
  endtask

  task automatic reconfigure(input logic [CFG_DATA_W-1:0] win_data,
                             input logic [CFG_DATA_W-1:0] thr_data);
    if ($urandom_range(0, 1) == 1) begin
      write_reg(CFG_WINDOW_LEN, win_data);
      write_reg(CFG_THRESHOLD, thr_data);
    end else begin
      write_reg(CFG_THRESHOLD, thr_data);
      write_reg(CFG_WINDOW_LEN, win_data);
    end
    cfg_if.valid <= 1'b0;
  endtask

  // stop sending, let every expected window drain, then let queue work finish
  task automatic quiesce();
    samples_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic send_quiet_run(input int amp, input int unsigned len, input bit may_restart);
    int base;
    int v;
    base = $urandom_range(0, 65535) - 32768;
    repeat (len) begin
      v = base + int'($urandom_range(0, 2 * amp)) - amp;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      push_sample(SAMPLE_W'(v), may_restart && ($urandom_range(0, 39) == 0));
    end
  endtask

  task automatic send_noise_run(input int unsigned len);
    logic [SAMPLE_W-1:0] value;
    repeat (len) begin
      case ($urandom_range(0, 3))
        0: value = 16'h8000;
        1: value = 16'h7fff;
        default: value = SAMPLE_W'($urandom);
      endcase
      push_sample(value, $urandom_range(0, 39) == 0);
    end
  endtask

  initial begin : stimulus
    int unsigned p;
    int unsigned win_len;
    int unsigned eff_win;
    int unsigned thr;
    int unsigned amp;
    int unsigned mark;
    rst_ni             <= 1'b0;
    cfg_if.valid       <= 1'b0;
    cfg_if.index       <= CFG_WINDOW_LEN;
    cfg_if.data        <= '0;
    samples_if.valid   <= 1'b0;
    samples_if.sample  <= '0;
    samples_if.restart <= 1'b0;
    idle_en      = 1'b1;
    beats_sent   = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset config: every sample is a silent one-sample window
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h0000, 1'b1);
    push_sample(16'hffff, 1'b0);
    push_sample(16'h0001, 1'b0);
    quiesce();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
    // zero window length acts as one
    reconfigure(16'h0000, 16'hffff);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b0);
    quiesce();
    // full-scale spread at the largest threshold, short window after restart
    reconfigure(16'd2, 16'hffff);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h0005, 1'b1);
    push_sample(16'h0005, 1'b0);
    quiesce();
    reconfigure(16'd3, 16'hfffe);
    push_sample(16'h8000, 1'b0);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h7fff, 1'b0);
    push_sample(16'h7ffe, 1'b0);

    for (p = 0; p < PHASES; p++) begin
      if (p == LARGE_PHASE) begin
        win_len = WINDOW_MAX + $urandom_range(1, 64);
        thr     = $urandom_range(100, 400);
      end else begin
        case ($urandom_range(0, 5))
          0: win_len = 0;
          1: win_len = 1;
          2: win_len = $urandom_range(2, 4);
          3, 4: win_len = $urandom_range(5, 16);
          default: win_len = $urandom_range(17, 64);
        endcase
        case ($urandom_range(0, 4))
          0: thr = 0;
          1: thr = 65535;
          2, 3: thr = $urandom_range(1, 64);
          default: thr = $urandom_range(65, 4000);
        endcase
      end
      eff_win = (win_len == 0) ? 1 : ((win_len > WINDOW_MAX) ? WINDOW_MAX : win_len);
      idle_en = (p % 3 != 2);
      quiesce();
      reconfigure({(CFG_DATA_W - WIN_LEN_W)'($urandom), WIN_LEN_W'(win_len)},
                  CFG_DATA_W'(thr));
      if (p == LARGE_PHASE) begin
        // window above the queue depth is capped there, so no window closes
        send_quiet_run(40, LARGE_RUN, 1'b0);
      end else begin
        mark = beats_sent;
        while (beats_sent - mark < PHASE_BEATS) begin
          if ($urandom_range(0, 4) < 3) begin
            amp = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, thr / 2 + 1);
            send_quiet_run(amp, $urandom_range(eff_win, 2 * eff_win + 6), 1'b1);
          end else begin
            send_noise_run($urandom_range(1, 6));
          end
        end
      end
    end

    // closing stretch without idling on either side
    idle_en = 1'b0;
    quiesce();
    reconfigure({(CFG_DATA_W - WIN_LEN_W)'($urandom), WIN_LEN_W'(4)}, 16'd32);
    mark = beats_sent;
    while (beats_sent - mark < PHASE_BEATS) begin
      if ($urandom_range(0, 3) != 0) begin
        send_quiet_run($urandom_range(0, 20), $urandom_range(4, 12), 1'b1);
      end else begin
        send_noise_run($urandom_range(1, 4));
      end
    end
    quiesce();

    if (errors == 0 && pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### sim.f
rtl/swsd_pkg.sv
rtl/swsd_if.sv
rtl/swsd_ram.sv
rtl/swsd_queue.sv
rtl/sliding_window_silence_detector_top.sv
tb/swsd_silence_checker.sv
tb/sliding_window_silence_detector_top_tb.sv
